FILE: rtl/led_matrix_char_column_generator_unit_defines.svh
// Assertion macros for the LED matrix column generator checker.
// Used by lmcg_checker.sv; expects clk and rst_n in scope.
`ifndef LED_MATRIX_CHAR_COLUMN_GENERATOR_UNIT_DEFINES_SVH
`define LED_MATRIX_CHAR_COLUMN_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LMCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmcg: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define LMCG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmcg: next-cycle check failed");

`endif

FILE: rtl/lmcg_pkg.sv
// Shared types, constants and font ROM for the LED matrix column generator.
// No dependencies.
package lmcg_pkg;

  localparam logic [7:0] FIRST_CODE  = 8'd32;
  localparam logic [7:0] LAST_CODE   = 8'd127;
  localparam logic [2:0] GLYPH_COLS  = 3'd5;
  localparam int         GLYPH_COUNT = 96;

  typedef enum logic [1:0] {
    REG_PAD   = 2'd0,
    REG_MONO  = 2'd1,
    REG_BLANK = 2'd2,
    REG_LAST  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] pad;
    logic       mono;
    logic [2:0] blank;
    logic [6:0] last;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{pad: 3'd0, mono: 1'b0, blank: 3'd0, last: 7'd31};

  // One character job: column 0 sits in the top byte of word.
  typedef struct packed {
    logic [6:0]  col;
    logic [39:0] word;
    logic [3:0]  cnt;
    logic        trunc;
    logic        tglyph;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [39:0] FONT [GLYPH_COUNT] = '{
    40'h0000000000, 40'h0000FA0000, 40'h00C000C000, 40'h28FE28FE28,
    40'h2454FE5448, 40'hC4C8102646, 40'h6C92AA440A, 40'h00A0C00000,
    40'h0038448200, 40'h0082443800, 40'h28107C1028, 40'h10107C1010,
    40'h0005060000, 40'h1010101010, 40'h0006060000, 40'h0408102040,
    40'h7C8282827C, 40'h0042FE0200, 40'h42868A9262, 40'h8482A2D28C,
    40'h182848FE08, 40'hE4A2A2A29C, 40'h3C5292920C, 40'h808E90A0C0,
    40'h6C9292926C, 40'h6092929478, 40'h006C6C0000, 40'h0065660000,
    40'h1028448200, 40'h2828282828, 40'h0082442810, 40'h40808A9060,
    40'h4C929E827C, 40'h7E8888887E, 40'hFE9292926C, 40'h7C82828244,
    40'hFE82824438, 40'hFE92929282, 40'hFE90909080, 40'h7C8292925E,
    40'hFE101010FE, 40'h0082FE8200, 40'h040282FC80, 40'hFE10284482,
    40'hFE02020202, 40'hFE403040FE, 40'hFE201008FE, 40'h7C8282827C,
    40'hFE90909060, 40'h7C828A847A, 40'hFE90989462, 40'h629292928C,
    40'h8080FE8080, 40'hFC020202FC, 40'hF8040204F8, 40'hFC021C02FC,
    40'hC6281028C6, 40'hE0100E10E0, 40'h868A92A2C2, 40'h00FE828200,
    40'h4020100804, 40'h008282FE00, 40'h2040804020, 40'h0101010101,
    40'h0080402000, 40'h042A2A2A1E, 40'hFE1222221C, 40'h1C22222204,
    40'h1C222212FE, 40'h1C2A2A2A18, 40'h107E908040, 40'h182525253E,
    40'hFE1020201E, 40'h0022BE0200, 40'h020121BE00, 40'hFE08142200,
    40'h0082FE0200, 40'h3E2018201E, 40'h3E1020201E, 40'h1C2222221C,
    40'h3F24242418, 40'h182424341F, 40'h3E10202010, 40'h122A2A2A04,
    40'h20FC220204, 40'h3C0202043E, 40'h3804020438, 40'h3C020C023C,
    40'h2214081422, 40'h380505053E, 40'h22262A3222, 40'h00106C8200,
    40'h0000FE0000, 40'h00826C1000, 40'h0810100810, 40'h000040A040
  };

endpackage

FILE: rtl/lmcg_front.sv
// Front end: configuration registers, font lookup, trimming and clipping.
// Depends on lmcg_pkg; feeds lmcg_queue.
module lmcg_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [6:0]     in_start_column,
  input  logic [7:0]     in_char_code,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [6:0]     cfg_data,
  output logic           push,
  output lmcg_pkg::desc_t desc
);
  import lmcg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PAD:   cfg_nxt.pad   = cfg_data[2:0];
        REG_MONO:  cfg_nxt.mono  = cfg_data[0];
        REG_BLANK: cfg_nxt.blank = cfg_data[2:0];
        REG_LAST:  cfg_nxt.last  = cfg_data;
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign push = accept;

  always_comb begin
    logic        item_ok;
    logic [39:0] glyph;
    logic [39:0] word;
    logic [4:0]  nz;
    logic [2:0]  first;
    logic [2:0]  lastnz;
    logic [2:0]  w;
    logic [2:0]  ng;
    logic [2:0]  gw;
    logic [2:0]  pw;
    logic [7:0]  avail;
    logic [7:0]  rem;
    logic        tglyph;
    logic        tpad;

    item_ok = (in_start_column <= cfg_r.last) &&
              (in_char_code >= FIRST_CODE) && (in_char_code <= LAST_CODE);
    glyph   = FONT[7'(in_char_code - FIRST_CODE)];

    for (int i = 0; i < 5; i++) begin
      nz[i] = |glyph[39-8*i -: 8];
    end
    first  = 3'd0;
    lastnz = 3'd0;
    for (int i = 4; i >= 0; i--) begin
      if (nz[i]) first = 3'(i);
    end
    for (int i = 0; i < 5; i++) begin
      if (nz[i]) lastnz = 3'(i);
    end

    if (cfg_r.mono) begin
      word = glyph;
      w    = GLYPH_COLS;
    end else begin
      word = glyph << {first, 3'b000};
      w    = (|nz) ? 3'(lastnz - first + 3'd1) : 3'd0;
    end

    ng     = (w != 3'd0) ? w : cfg_r.blank;
    avail  = {1'b0, cfg_r.last} - {1'b0, in_start_column} + 8'd1;
    tglyph = {5'b0, ng} > avail;
    gw     = tglyph ? avail[2:0] : ng;
    rem    = avail - {5'b0, ng};
    tpad   = !tglyph && ({5'b0, cfg_r.pad} > rem);
    if (tglyph) begin
      pw = 3'd0;
    end else if (tpad) begin
      pw = rem[2:0];
    end else begin
      pw = cfg_r.pad;
    end

    desc.col    = in_start_column;
    desc.word   = item_ok ? word : 40'd0;
    desc.cnt    = item_ok ? ({1'b0, gw} + {1'b0, pw}) : 4'd0;
    desc.trunc  = item_ok && (tglyph || tpad);
    desc.tglyph = item_ok && tglyph;
  end

endmodule

FILE: rtl/lmcg_queue.sv
// Two-entry job queue between front end and column sequencer.
// Depends on lmcg_pkg.
module lmcg_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lmcg_pkg::desc_t  push_desc,
  input  logic             pop,
  output lmcg_pkg::desc_t  head,
  output lmcg_pkg::q_stat_t stat
);
  import lmcg_pkg::*;

  desc_t      mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = count_r[1];
  assign stat.empty = (count_r == 2'd0);

endmodule

FILE: rtl/lmcg_back.sv
// Column sequencer: emits one display column or status word per cycle.
// Depends on lmcg_pkg; drains lmcg_queue.
module lmcg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lmcg_pkg::desc_t   head,
  input  lmcg_pkg::q_stat_t stat,
  output logic              pop,
  output logic              out_valid,
  output logic              out_write_valid,
  output logic [6:0]        out_column_addr,
  output logic [7:0]        out_column_bits,
  output logic              out_last,
  output logic [3:0]        out_columns_out,
  output logic              out_truncated,
  output logic              out_truncated_in_glyph
);
  import lmcg_pkg::*;

  logic        active_r;
  logic        active_nxt;
  desc_t       job_r;
  desc_t       job_nxt;
  logic [3:0]  idx_r;
  logic [3:0]  idx_nxt;
  logic        has_write;
  logic        last_now;

  assign has_write = (job_r.cnt != 4'd0);
  assign last_now  = has_write ? (idx_r == job_r.cnt - 4'd1) : 1'b1;
  assign pop       = (!active_r || last_now) && !stat.empty;

  always_comb begin
    active_nxt = active_r;
    job_nxt    = job_r;
    idx_nxt    = idx_r;
    if (pop) begin
      active_nxt = 1'b1;
      job_nxt    = head;
      idx_nxt    = 4'd0;
    end else if (active_r && last_now) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      idx_nxt      = idx_r + 4'd1;
      job_nxt.word = job_r.word << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
  end

  assign out_valid              = active_r;
  assign out_write_valid        = has_write;
  assign out_column_addr        = has_write ? (job_r.col + {3'b0, idx_r}) : 7'd0;
  assign out_column_bits        = has_write ? job_r.word[39:32] : 8'd0;
  assign out_last               = last_now;
  assign out_columns_out        = last_now ? job_r.cnt : 4'd0;
  assign out_truncated          = last_now && job_r.trunc;
  assign out_truncated_in_glyph = last_now && job_r.tglyph;

endmodule

FILE: rtl/led_matrix_char_column_generator_unit.sv
// Top level of the LED matrix character column generator.
// Depends on lmcg_pkg, lmcg_front, lmcg_queue and lmcg_back.
//
//   channel  handshake              payload
//   in       start / busy           in_start_column, in_char_code
//   out      out_valid (strobe)     out_write_valid .. out_truncated_in_glyph
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A character is sent as one column per cycle (1 to 14 columns written), or as
// a single status-only word; the column sequencer sets the rate.
// A character passes through the queue and the sequencer's job register; the
// two-entry queue takes a new character while the previous one is being sent.
// busy is high while the queue is full. Reset is synchronous, active low, and
// restores the register defaults. Results cannot be stalled.
module led_matrix_char_column_generator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [6:0] in_start_column,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  output logic       out_write_valid,
  output logic [6:0] out_column_addr,
  output logic [7:0] out_column_bits,
  output logic       out_last,
  output logic [3:0] out_columns_out,
  output logic       out_truncated,
  output logic       out_truncated_in_glyph,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import lmcg_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  desc_t   push_desc;
  desc_t   head;
  q_stat_t stat;

  assign cfg_ready = 1'b1;
  assign busy      = stat.full;
  assign accept    = start && !busy;

  lmcg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_start_column (in_start_column),
    .in_char_code    (in_char_code),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .desc            (push_desc)
  );

  lmcg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  lmcg_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head                   (head),
    .stat                   (stat),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_write_valid        (out_write_valid),
    .out_column_addr        (out_column_addr),
    .out_column_bits        (out_column_bits),
    .out_last               (out_last),
    .out_columns_out        (out_columns_out),
    .out_truncated          (out_truncated),
    .out_truncated_in_glyph (out_truncated_in_glyph)
  );

endmodule

FILE: rtl/lmcg_checker.sv
// Port-level checks for the LED matrix column generator, bound to the top.
// Depends on led_matrix_char_column_generator_unit_defines.svh.
`include "led_matrix_char_column_generator_unit_defines.svh"

module lmcg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_write_valid,
  input logic [6:0] out_column_addr,
  input logic       out_last,
  input logic [3:0] out_columns_out,
  input logic       out_truncated,
  input logic       out_truncated_in_glyph
);

  `LMCG_ASSERT_IMP(a_status_is_last, out_valid && !out_write_valid, out_last)
  `LMCG_ASSERT_NXT(a_char_contiguous, out_valid && !out_last, out_valid && out_write_valid)
  `LMCG_ASSERT_NXT(a_addr_advance, out_valid && !out_last, out_column_addr == $past(out_column_addr) + 7'd1)
  `LMCG_ASSERT_IMP(a_status_only_last, out_valid && !out_last, out_columns_out == 4'd0 && !out_truncated && !out_truncated_in_glyph)
  `LMCG_ASSERT_IMP(a_glyph_cut_implies_cut, out_valid && out_truncated_in_glyph, out_truncated)

endmodule

bind led_matrix_char_column_generator_unit lmcg_checker u_lmcg_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for led_matrix_char_column_generator_unit.
// Predicts every column word from its own font table and register copies.
// Depends on lmcg_pkg for the register index codes and code range limits.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lmcg_pkg::*;

  typedef struct {
    bit [6:0] col;
    bit [7:0] code;
    int       gap;
  } char_job_t;

  typedef struct packed {
    bit       wv;
    bit [6:0] addr;
    bit [7:0] bits;
    bit       last;
    bit [3:0] cnt;
    bit       trunc;
    bit       tglyph;
  } col_word_t;

  localparam bit [7:0] GLYPH_BYTES [480] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFA,8'h00,8'h00,
    8'h00,8'hC0,8'h00,8'hC0,8'h00,8'h28,8'hFE,8'h28,8'hFE,8'h28,
    8'h24,8'h54,8'hFE,8'h54,8'h48,8'hC4,8'hC8,8'h10,8'h26,8'h46,
    8'h6C,8'h92,8'hAA,8'h44,8'h0A,8'h00,8'hA0,8'hC0,8'h00,8'h00,
    8'h00,8'h38,8'h44,8'h82,8'h00,8'h00,8'h82,8'h44,8'h38,8'h00,
    8'h28,8'h10,8'h7C,8'h10,8'h28,8'h10,8'h10,8'h7C,8'h10,8'h10,
    8'h00,8'h05,8'h06,8'h00,8'h00,8'h10,8'h10,8'h10,8'h10,8'h10,
    8'h00,8'h06,8'h06,8'h00,8'h00,8'h04,8'h08,8'h10,8'h20,8'h40,
    8'h7C,8'h82,8'h82,8'h82,8'h7C,8'h00,8'h42,8'hFE,8'h02,8'h00,
    8'h42,8'h86,8'h8A,8'h92,8'h62,8'h84,8'h82,8'hA2,8'hD2,8'h8C,
    8'h18,8'h28,8'h48,8'hFE,8'h08,8'hE4,8'hA2,8'hA2,8'hA2,8'h9C,
    8'h3C,8'h52,8'h92,8'h92,8'h0C,8'h80,8'h8E,8'h90,8'hA0,8'hC0,
    8'h6C,8'h92,8'h92,8'h92,8'h6C,8'h60,8'h92,8'h92,8'h94,8'h78,
    8'h00,8'h6C,8'h6C,8'h00,8'h00,8'h00,8'h65,8'h66,8'h00,8'h00,
    8'h10,8'h28,8'h44,8'h82,8'h00,8'h28,8'h28,8'h28,8'h28,8'h28,
    8'h00,8'h82,8'h44,8'h28,8'h10,8'h40,8'h80,8'h8A,8'h90,8'h60,
    8'h4C,8'h92,8'h9E,8'h82,8'h7C,8'h7E,8'h88,8'h88,8'h88,8'h7E,
    8'hFE,8'h92,8'h92,8'h92,8'h6C,8'h7C,8'h82,8'h82,8'h82,8'h44,
    8'hFE,8'h82,8'h82,8'h44,8'h38,8'hFE,8'h92,8'h92,8'h92,8'h82,
    8'hFE,8'h90,8'h90,8'h90,8'h80,8'h7C,8'h82,8'h92,8'h92,8'h5E,
    8'hFE,8'h10,8'h10,8'h10,8'hFE,8'h00,8'h82,8'hFE,8'h82,8'h00,
    8'h04,8'h02,8'h82,8'hFC,8'h80,8'hFE,8'h10,8'h28,8'h44,8'h82,
    8'hFE,8'h02,8'h02,8'h02,8'h02,8'hFE,8'h40,8'h30,8'h40,8'hFE,
    8'hFE,8'h20,8'h10,8'h08,8'hFE,8'h7C,8'h82,8'h82,8'h82,8'h7C,
    8'hFE,8'h90,8'h90,8'h90,8'h60,8'h7C,8'h82,8'h8A,8'h84,8'h7A,
    8'hFE,8'h90,8'h98,8'h94,8'h62,8'h62,8'h92,8'h92,8'h92,8'h8C,
    8'h80,8'h80,8'hFE,8'h80,8'h80,8'hFC,8'h02,8'h02,8'h02,8'hFC,
    8'hF8,8'h04,8'h02,8'h04,8'hF8,8'hFC,8'h02,8'h1C,8'h02,8'hFC,
    8'hC6,8'h28,8'h10,8'h28,8'hC6,8'hE0,8'h10,8'h0E,8'h10,8'hE0,
    8'h86,8'h8A,8'h92,8'hA2,8'hC2,8'h00,8'hFE,8'h82,8'h82,8'h00,
    8'h40,8'h20,8'h10,8'h08,8'h04,8'h00,8'h82,8'h82,8'hFE,8'h00,
    8'h20,8'h40,8'h80,8'h40,8'h20,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h00,8'h80,8'h40,8'h20,8'h00,8'h04,8'h2A,8'h2A,8'h2A,8'h1E,
    8'hFE,8'h12,8'h22,8'h22,8'h1C,8'h1C,8'h22,8'h22,8'h22,8'h04,
    8'h1C,8'h22,8'h22,8'h12,8'hFE,8'h1C,8'h2A,8'h2A,8'h2A,8'h18,
    8'h10,8'h7E,8'h90,8'h80,8'h40,8'h18,8'h25,8'h25,8'h25,8'h3E,
    8'hFE,8'h10,8'h20,8'h20,8'h1E,8'h00,8'h22,8'hBE,8'h02,8'h00,
    8'h02,8'h01,8'h21,8'hBE,8'h00,8'hFE,8'h08,8'h14,8'h22,8'h00,
    8'h00,8'h82,8'hFE,8'h02,8'h00,8'h3E,8'h20,8'h18,8'h20,8'h1E,
    8'h3E,8'h10,8'h20,8'h20,8'h1E,8'h1C,8'h22,8'h22,8'h22,8'h1C,
    8'h3F,8'h24,8'h24,8'h24,8'h18,8'h18,8'h24,8'h24,8'h34,8'h1F,
    8'h3E,8'h10,8'h20,8'h20,8'h10,8'h12,8'h2A,8'h2A,8'h2A,8'h04,
    8'h20,8'hFC,8'h22,8'h02,8'h04,8'h3C,8'h02,8'h02,8'h04,8'h3E,
    8'h38,8'h04,8'h02,8'h04,8'h38,8'h3C,8'h02,8'h0C,8'h02,8'h3C,
    8'h22,8'h14,8'h08,8'h14,8'h22,8'h38,8'h05,8'h05,8'h05,8'h3E,
    8'h22,8'h26,8'h2A,8'h32,8'h22,8'h00,8'h10,8'h6C,8'h82,8'h00,
    8'h00,8'h00,8'hFE,8'h00,8'h00,8'h00,8'h82,8'h6C,8'h10,8'h00,
    8'h08,8'h10,8'h10,8'h08,8'h10,8'h00,8'h00,8'h40,8'hA0,8'h40
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [6:0] in_start_column = '0;
  logic [7:0] in_char_code = '0;
  logic       out_valid;
  logic       out_write_valid;
  logic [6:0] out_column_addr;
  logic [7:0] out_column_bits;
  logic       out_last;
  logic [3:0] out_columns_out;
  logic       out_truncated;
  logic       out_truncated_in_glyph;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  bit [2:0] cur_pad = 3'd0;
  bit       cur_mono = 1'b0;
  bit [2:0] cur_blank = 3'd0;
  bit [6:0] cur_last = 7'd31;

  char_job_t glyph_jobs[$];
  col_word_t expected_words[$];
  int        gap_left = -1;
  int        errors = 0;
  int        chars_accepted = 0;
  int        words_checked = 0;
  int        column_writes = 0;
  int        cut_chars = 0;
  int        settings_used = 0;

  led_matrix_char_column_generator_unit u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_start_column        (in_start_column),
    .in_char_code           (in_char_code),
    .out_valid              (out_valid),
    .out_write_valid        (out_write_valid),
    .out_column_addr        (out_column_addr),
    .out_column_bits        (out_column_bits),
    .out_last               (out_last),
    .out_columns_out        (out_columns_out),
    .out_truncated          (out_truncated),
    .out_truncated_in_glyph (out_truncated_in_glyph),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic col_word_t column_word(int addr, bit [7:0] bits);
    col_word_t wd;
    wd = '0;
    wd.wv = 1'b1;
    wd.addr = addr[6:0];
    wd.bits = bits;
    return wd;
  endfunction

  // Compute the column words one character produces under the current registers.
  function automatic void render_char(bit [6:0] col, bit [7:0] code);
    bit [7:0]  cols [5];
    col_word_t words[$];
    col_word_t wd;
    int        w, first, lastnz, n, cnt, p, i;
    bit        trunc, tglyph;
    w = 0;
    cnt = 0;
    trunc = 1'b0;
    tglyph = 1'b0;
    for (i = 0; i < 5; i++) cols[i] = 8'h00;
    if (col <= cur_last && code >= FIRST_CODE && code <= LAST_CODE) begin
      first = -1;
      lastnz = -1;
      for (i = 0; i < 5; i++) begin
        if (GLYPH_BYTES[(int'(code) - 32) * 5 + i] != 8'h00) begin
          if (first < 0) first = i;
          lastnz = i;
        end
      end
      if (cur_mono) begin
        for (i = 0; i < 5; i++) cols[i] = GLYPH_BYTES[(int'(code) - 32) * 5 + i];
        w = 5;
      end else if (first >= 0) begin
        w = lastnz - first + 1;
        for (i = 0; i < w; i++) cols[i] = GLYPH_BYTES[(int'(code) - 32) * 5 + first + i];
      end
      n = (w == 0) ? int'(cur_blank) : w;
      for (i = 0; i < n; i++) begin
        if (int'(col) + i > int'(cur_last)) break;
        words.push_back(column_word(int'(col) + i, (w == 0) ? 8'h00 : cols[i]));
        cnt++;
      end
      if (cnt != n) begin
        trunc = 1'b1;
        tglyph = 1'b1;
      end
      if (!trunc && cur_pad != 3'd0) begin
        p = 0;
        for (i = 0; i < int'(cur_pad); i++) begin
          if (int'(col) + cnt + i > int'(cur_last)) break;
          words.push_back(column_word(int'(col) + cnt + i, 8'h00));
          p++;
        end
        cnt += p;
        if (p != int'(cur_pad)) trunc = 1'b1;
      end
    end
    if (words.size() == 0) words.push_back('0);
    wd = words.pop_back();
    wd.last = 1'b1;
    wd.cnt = cnt[3:0];
    wd.trunc = trunc;
    wd.tglyph = tglyph;
    words.push_back(wd);
    foreach (words[k]) expected_words.push_back(words[k]);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : drive
    int gap_now;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= -1;
    end else begin
      if (start && !busy) begin
        render_char(in_start_column, in_char_code);
        void'(glyph_jobs.pop_front());
        chars_accepted++;
      end
      if (start && busy) begin
        // hold the word until the block takes it
      end else if (glyph_jobs.size() == 0) begin
        start <= 1'b0;
      end else begin
        gap_now = (gap_left < 0) ? glyph_jobs[0].gap : gap_left;
        if (gap_now == 0) begin
          start <= 1'b1;
          in_start_column <= glyph_jobs[0].col;
          in_char_code <= glyph_jobs[0].code;
          gap_left <= -1;
        end else begin
          start <= 1'b0;
          gap_left <= gap_now - 1;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    col_word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word at column %0d", out_column_addr);
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("write_valid", want.wv, out_write_valid);
        check_field("column_addr", want.addr, out_column_addr);
        check_field("column_bits", want.bits, out_column_bits);
        check_field("last", want.last, out_last);
        check_field("columns_out", want.cnt, out_columns_out);
        check_field("truncated", want.trunc, out_truncated);
        check_field("truncated_in_glyph", want.tglyph, out_truncated_in_glyph);
        words_checked++;
        if (out_write_valid) column_writes++;
        if (out_last && out_truncated) cut_chars++;
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, bit [6:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      REG_PAD:   cur_pad = value[2:0];
      REG_MONO:  cur_mono = value[0];
      REG_BLANK: cur_blank = value[2:0];
      REG_LAST:  cur_last = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(int pad, int mono, int blank, int last_col);
    cfg_write(REG_PAD, 7'(pad));
    cfg_write(REG_MONO, 7'(mono));
    cfg_write(REG_BLANK, 7'(blank));
    cfg_write(REG_LAST, 7'(last_col));
    settings_used++;
    @(negedge clk);
  endtask

  task automatic queue_char(int col, int code, int gap);
    char_job_t job;
    job.col = 7'(col);
    job.code = 8'(code);
    job.gap = gap;
    glyph_jobs.push_back(job);
  endtask

  task automatic drain();
    while (glyph_jobs.size() != 0 || expected_words.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int       p, n, col, code;
    bit       calm;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    settings_used = 1;

    queue_char(0, 65, $urandom_range(0, 11));
    queue_char(127, 65, $urandom_range(0, 11));
    queue_char(0, 0, $urandom_range(0, 11));
    queue_char(5, 31, $urandom_range(0, 11));
    queue_char(5, 128, $urandom_range(0, 11));
    queue_char(5, 255, $urandom_range(0, 11));
    queue_char(0, 32, $urandom_range(0, 11));
    queue_char(31, 127, $urandom_range(0, 11));
    queue_char(29, 87, $urandom_range(0, 11));
    queue_char(10, 33, $urandom_range(0, 11));
    queue_char(3, 34, $urandom_range(0, 11));
    drain();

    apply_setting(7, 1, 7, 127);
    queue_char(0, 32, $urandom_range(0, 11));
    queue_char(120, 65, $urandom_range(0, 11));
    queue_char(123, 65, $urandom_range(0, 11));
    queue_char(124, 65, $urandom_range(0, 11));
    queue_char(127, 127, $urandom_range(0, 11));
    drain();

    apply_setting(7, 0, 7, 127);
    queue_char(0, 32, $urandom_range(0, 11));
    queue_char(115, 32, $urandom_range(0, 11));
    queue_char(126, 32, $urandom_range(0, 11));
    drain();

    apply_setting(0, 0, 3, 0);
    queue_char(0, 33, $urandom_range(0, 11));
    queue_char(0, 65, $urandom_range(0, 11));
    queue_char(1, 65, $urandom_range(0, 11));
    queue_char(0, 32, $urandom_range(0, 11));
    queue_char(0, 127, $urandom_range(0, 11));
    drain();

    for (p = 0; p < 10; p++) begin
      if (p == 0) apply_setting(7, 1, 7, 127);
      else if (p == 1) apply_setting(0, 0, 0, 0);
      else apply_setting($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 7),
                         ($urandom_range(0, 3) == 0) ? 127 : $urandom_range(0, 127));
      calm = (p % 3 == 0);
      for (n = 0; n < 48; n++) begin
        case ($urandom_range(0, 3))
          0: col = $urandom_range(0, 127);
          1: col = (cur_last > 14) ? $urandom_range(cur_last - 14, cur_last)
                                   : $urandom_range(0, cur_last);
          default: col = $urandom_range(0, cur_last);
        endcase
        case ($urandom_range(0, 15))
          0, 1: code = $urandom_range(0, 255);
          2: code = 32;
          default: code = $urandom_range(32, 127);
        endcase
        queue_char(col, code, calm ? 0 : $urandom_range(0, 11));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("%0d characters over %0d register settings, %0d words checked",
             chars_accepted, settings_used, words_checked);
    $display("%0d column writes, %0d characters cut at the display edge",
             column_writes, cut_chars);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule
